// ===== hw/rtl/ddeh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddeh_pkg: shared definitions for the dual-detector energy histogram
// Constants, field widths and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package ddeh_pkg;

    // Default histogram depth, one bin per keV
    localparam int NBINS_DEF = 8192;

    // Field widths
    localparam int ENERGY_W = 24;
    localparam int RBIN_W   = 13;
    localparam int MAXE_W   = 14;
    localparam int CNT_W    = 32;
    localparam int TOT_W    = 48;
    localparam int KEV_W    = 16;  // integer keV part of Q16.8
    localparam int FRAC_W   = 8;
    localparam int CMP_W    = 17;  // wide enough to hold NBINS itself

    // Reset value of the energy limit register
    localparam logic [MAXE_W-1:0] MAXE_RST = 14'd8192;

    // Saturation limits
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

    // Operation codes
    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic clear_step;  // zero one bin of both histograms
        logic capture;     // take in the accepted item, start the bin read
        logic commit;      // write back, update totals, load the result
    } t_ctrl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clear_last;  // the clearing pass is at its final bin
    } t_ctrl_sts;

endpackage

// ===== hw/rtl/ddeh_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddeh_ctrl: sequencer for the energy histogram
// Runs the post-reset clearing pass, then steps each item through capture
// and commit, and owns the result valid flag.
// ----------------------------------------------------------------------------
module ddeh_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  ddeh_pkg::t_ctrl_sts i_sts,
    output ddeh_pkg::t_ctrl_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_UPD   = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state and commands
    always_comb begin
        n_state          = r_state;
        n_out_valid      = r_out_valid;
        o_cmd.clear_step = 1'b0;
        o_cmd.capture    = 1'b0;
        o_cmd.commit     = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_UPD;
                end
            end
            ST_UPD: begin
                // hold the item until the result slot is free
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Checks
    a_accept_to_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_UPD))
        else $error("accepted item did not move to update");
    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> r_out_valid)
        else $error("commit did not raise result valid");
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("pending result dropped");
    a_clear_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR && i_sts.clear_last) |=> (r_state == ST_IDLE))
        else $error("clearing pass did not finish");

endmodule

// ===== hw/rtl/ddeh_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddeh_dp: datapath for the energy histogram
// Two bin memories with read-modify-write, saturating totals, the energy
// limit register, the clearing counter and the result registers.
// ----------------------------------------------------------------------------
module ddeh_dp #(
    parameter int NBINS = ddeh_pkg::NBINS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ddeh_pkg::t_ctrl_cmd               i_cmd,
    output ddeh_pkg::t_ctrl_sts               o_sts,
    input  logic                              i_cfg_we,
    input  logic [ddeh_pkg::MAXE_W-1:0]       i_cfg_data,
    input  logic                              i_opcode,
    input  logic                              i_detector,
    input  logic [ddeh_pkg::ENERGY_W-1:0]     i_energy_kev_q8,
    input  logic [ddeh_pkg::RBIN_W-1:0]       i_read_bin,
    output logic                              o_in_range,
    output logic [ddeh_pkg::CNT_W-1:0]        o_bin_count,
    output logic [ddeh_pkg::TOT_W-1:0]        o_total_energy_q8,
    output logic [ddeh_pkg::CNT_W-1:0]        o_total_events
);

    localparam int ADDR_W = (NBINS > 1) ? $clog2(NBINS) : 1;
    localparam logic [ddeh_pkg::CMP_W-1:0] NBINS_C = ddeh_pkg::CMP_W'(NBINS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NBINS - 1);

    // Bin memories, one per detector
    logic [ddeh_pkg::CNT_W-1:0] mem0 [NBINS];
    logic [ddeh_pkg::CNT_W-1:0] mem1 [NBINS];

    logic [ddeh_pkg::MAXE_W-1:0]   r_max_e;
    logic [ADDR_W-1:0]             r_clr_addr;
    logic [ddeh_pkg::CNT_W-1:0]    r_rdata0, r_rdata1;
    logic [ADDR_W-1:0]             r_addr;
    logic                          r_det, r_op, r_hit, r_rd_ok;
    logic [ddeh_pkg::ENERGY_W-1:0] r_energy;
    logic [ddeh_pkg::TOT_W-1:0]    r_tot0, r_tot1;
    logic [ddeh_pkg::CNT_W-1:0]    r_evt0, r_evt1;

    logic [ddeh_pkg::CMP_W-1:0]  bin_w, rbin_w, addr_w;
    logic                        hit, rd_ok;
    logic [ddeh_pkg::CNT_W-1:0]  cnt_old, cnt_new, cnt_out;
    logic [ddeh_pkg::TOT_W-1:0]  tot_old, tot_new;
    logic [ddeh_pkg::TOT_W:0]    tot_sum;
    logic [ddeh_pkg::CNT_W-1:0]  evt_old, evt_new;
    logic                        rec, wr_bin;

    // Address decode on the incoming item
    assign bin_w  = ddeh_pkg::CMP_W'(i_energy_kev_q8[ddeh_pkg::ENERGY_W-1:ddeh_pkg::FRAC_W]);
    assign rbin_w = ddeh_pkg::CMP_W'(i_read_bin);
    assign hit    = (i_opcode == ddeh_pkg::OP_RECORD)
                 && (bin_w < ddeh_pkg::CMP_W'(r_max_e)) && (bin_w < NBINS_C);
    assign rd_ok  = (i_opcode == ddeh_pkg::OP_READ) && (rbin_w < NBINS_C);
    assign addr_w = (i_opcode == ddeh_pkg::OP_READ) ? rbin_w : bin_w;

    assign o_sts.clear_last = (r_clr_addr == LAST_ADDR);

    // Update arithmetic for the captured item
    assign rec     = (r_op == ddeh_pkg::OP_RECORD);
    assign cnt_old = r_det ? r_rdata1 : r_rdata0;
    assign cnt_new = (cnt_old == ddeh_pkg::CNT_MAX) ? cnt_old : cnt_old + 1'b1;
    assign cnt_out = (rec && r_hit) ? cnt_new : ((!rec && r_rd_ok) ? cnt_old : '0);
    assign tot_old = r_det ? r_tot1 : r_tot0;
    assign tot_sum = {1'b0, tot_old} + (ddeh_pkg::TOT_W + 1)'(r_energy);
    assign tot_new = tot_sum[ddeh_pkg::TOT_W] ? ddeh_pkg::TOT_MAX
                                              : tot_sum[ddeh_pkg::TOT_W-1:0];
    assign evt_old = r_det ? r_evt1 : r_evt0;
    assign evt_new = (evt_old == ddeh_pkg::CNT_MAX) ? evt_old : evt_old + 1'b1;
    assign wr_bin  = i_cmd.commit && rec && r_hit;

    // Energy limit register and clearing counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_e    <= ddeh_pkg::MAXE_RST;
            r_clr_addr <= '0;
        end else begin
            if (i_cfg_we) begin
                r_max_e <= i_cfg_data;
            end
            if (i_cmd.clear_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // Bin memories: clear, write back, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step) begin
            mem0[r_clr_addr] <= '0;
            mem1[r_clr_addr] <= '0;
        end else if (wr_bin) begin
            if (r_det) begin
                mem1[r_addr] <= cnt_new;
            end else begin
                mem0[r_addr] <= cnt_new;
            end
        end
        if (i_cmd.capture) begin
            r_rdata0 <= mem0[addr_w[ADDR_W-1:0]];
            r_rdata1 <= mem1[addr_w[ADDR_W-1:0]];
        end
    end

    // Captured item
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_addr   <= addr_w[ADDR_W-1:0];
            r_det    <= i_detector;
            r_op     <= i_opcode;
            r_hit    <= hit;
            r_rd_ok  <= rd_ok;
            r_energy <= i_energy_kev_q8;
        end
    end

    // Detector totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tot0 <= '0;
            r_tot1 <= '0;
            r_evt0 <= '0;
            r_evt1 <= '0;
        end else if (i_cmd.commit && rec) begin
            if (r_det) begin
                r_tot1 <= tot_new;
                r_evt1 <= evt_new;
            end else begin
                r_tot0 <= tot_new;
                r_evt0 <= evt_new;
            end
        end
    end

    // Result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_in_range        <= rec && r_hit;
            o_bin_count       <= cnt_out;
            o_total_energy_q8 <= rec ? tot_new : tot_old;
            o_total_events    <= rec ? evt_new : evt_old;
        end
    end

endmodule

// ===== hw/rtl/dual_detector_energy_histogram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_detector_energy_histogram: two-detector pulse-height analyzer
// Per-detector 1 keV energy histograms with saturating energy and event totals.
// ----------------------------------------------------------------------------
// Each item is captured, reading the addressed bin from its detector's memory,
// then committed once the result slot is free, writing the incremented count
// back and loading the result register; the next item is taken while a result
// still waits. After reset a clearing pass zeroes all NBINS bins of both
// histograms (8192 by default), one bin per cycle; no item is accepted until
// it ends, while writes to the energy limit register are taken at any time. A
// record item bins its integer keV part if below the limit register and NBINS.
module dual_detector_energy_histogram #(
    parameter int NBINS = ddeh_pkg::NBINS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ddeh_pkg::MAXE_W-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_opcode,
    input  logic                          i_detector,
    input  logic [ddeh_pkg::ENERGY_W-1:0] i_energy_kev_q8,
    input  logic [ddeh_pkg::RBIN_W-1:0]   i_read_bin,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_in_range,
    output logic [ddeh_pkg::CNT_W-1:0]    o_bin_count,
    output logic [ddeh_pkg::TOT_W-1:0]    o_total_energy_q8,
    output logic [ddeh_pkg::CNT_W-1:0]    o_total_events
);

    ddeh_pkg::t_ctrl_cmd cmd;
    ddeh_pkg::t_ctrl_sts sts;

    // Sequencer
    ddeh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Histogram memories and totals
    ddeh_dp #(
        .NBINS (NBINS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_opcode          (i_opcode),
        .i_detector        (i_detector),
        .i_energy_kev_q8   (i_energy_kev_q8),
        .i_read_bin        (i_read_bin),
        .o_in_range        (o_in_range),
        .o_bin_count       (o_bin_count),
        .o_total_energy_q8 (o_total_energy_q8),
        .o_total_events    (o_total_events)
    );

endmodule
